### sv/weighted_profile_accumulator_defines.svh
// Assertion macros shared by the checker.
`ifndef WEIGHTED_PROFILE_ACCUMULATOR_DEFINES_SVH
`define WEIGHTED_PROFILE_ACCUMULATOR_DEFINES_SVH

// Implication checked on every clock, off during reset.
`define WPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define WPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/wpa_pkg.sv
package wpa_pkg;

   localparam int NUM_BINS_DEFAULT = 64;
   localparam int BIN_W  = 6;
   localparam int VAL_W  = 16;
   localparam int WSUM_W = 40;
   localparam int S1_W   = 56;
   localparam int S2_W   = 64;
   localparam int CNT_W  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int RSP_DATA_W = 104;

   typedef enum logic {
      CMD_FILL = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [BIN_W-1:0]     bin;
      logic signed [VAL_W-1:0] value;
      logic [VAL_W-1:0]     weight;
   } op_type;

   typedef struct packed {
      logic [BIN_W-1:0]  read_bin;
      logic [15:0]       bin_mean;
      logic [15:0]       bin_rms;
      logic [CNT_W-1:0]  event_count;
      logic [15:0]       mean_error;
      logic [15:0]       rms_error;
      logic              bin_empty;
   } result_type;

endpackage

### sv/weighted_profile_accumulator.sv
// Weighted profile accumulator: 64 bins of (sum w, sum w*v, sum w*v^2).
// A fill word is a request latch with store read, then a saturating write
// back; a read word walks the shared divide/sqrt unit through mean, mean
// square, rms, and the two error terms, skipping the error terms when the
// count is below one and the unit entirely for an empty bin. The iterative
// unit produces one result bit per cycle. The back end takes no new word
// until the result word is taken. A 4-entry queue separates the request
// port from the back end. Bins start empty on reset through per-bin valid
// bits; no clearing pass is needed.
module weighted_profile_accumulator #(
   parameter int NUM_BINS = wpa_pkg::NUM_BINS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tuser,   // command
   input  logic [39:0]   req_tdata,   // bin_index, sample_value, sample_weight, pad
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata    // read_bin, bin_mean, bin_rms, event_count,
                                      // mean_error, rms_error, bin_empty, pad
);
   wpa_pkg::op_type     in_op, q_op;
   wpa_pkg::result_type r;
   logic q_valid, q_ready;

   always_comb begin
      in_op.cmd    = wpa_pkg::cmd_type'(req_tuser);
      in_op.bin    = req_tdata[5:0];
      in_op.value  = req_tdata[21:6];
      in_op.weight = req_tdata[37:22];
   end

   wpa_front #(.NUM_BINS(NUM_BINS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_op(in_op),
      .out_valid(q_valid), .out_ready(q_ready), .out_op(q_op)
   );

   wpa_back #(.NUM_BINS(NUM_BINS)) u_back (
      .clock(clock), .reset(reset),
      .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(r)
   );

   assign rsp_tdata = {1'b0, r.bin_empty, r.rms_error, r.mean_error, r.event_count,
                       r.bin_rms, r.bin_mean, r.read_bin};
endmodule

### sv/wpa_front.sv
// Accepts request words, drops fills to missing bins, and queues ops.
module wpa_front #(
   parameter int NUM_BINS = wpa_pkg::NUM_BINS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  wpa_pkg::op_type      in_op,
   output logic                 out_valid,
   input  logic                 out_ready,
   output wpa_pkg::op_type      out_op
);
   localparam int D = wpa_pkg::QUEUE_DEPTH;
   localparam int AW = $clog2(D);

   wpa_pkg::op_type  q_ff [D];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             push, pop, keep;

   assign in_ready  = cnt_ff != (AW+1)'(D);
   assign out_valid = cnt_ff != '0;
   assign out_op    = q_ff[rd_ff];
   assign keep = (in_op.cmd == wpa_pkg::CMD_READ) ||
                 ({26'd0, in_op.bin} < 32'(NUM_BINS));
   assign push = in_valid && in_ready && keep;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= in_op;
   end
endmodule

### sv/wpa_divsqrt.sv
// Shared iterative unit: unsigned divide (64/40, one quotient bit per cycle)
// or integer square root of a 64-bit value (one result bit per cycle).
module wpa_divsqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_sqrt,
   input  logic [63:0] num,
   input  logic [39:0] den,
   output logic        done,
   output logic [63:0] result
);
   logic [63:0] x_ff, x_in, r_ff, r_in;
   logic [39:0] rem_ff, rem_in;
   logic [39:0] den_ff;
   logic [6:0]  step_ff, step_in;
   logic        sq_ff, busy_ff, busy_in, done_ff;
   logic [63:0] b, trial;
   logic [40:0] rsh;

   assign done   = done_ff;
   assign result = r_ff;

   always_comb begin
      x_in = x_ff; r_in = r_ff; rem_in = rem_ff; step_in = step_ff; busy_in = busy_ff;
      b = 64'd1 << {step_ff[4:0], 1'b0};
      trial = r_ff + b;
      rsh = {rem_ff, x_ff[63]};
      if (start) begin
         x_in = num; r_in = '0; rem_in = '0; busy_in = 1'b1;
         step_in = is_sqrt ? 7'd31 : 7'd63;
      end else if (busy_ff) begin
         if (sq_ff) begin
            if (x_ff >= trial) begin
               x_in = x_ff - trial;
               r_in = (r_ff >> 1) + b;
            end else begin
               r_in = r_ff >> 1;
            end
         end else begin
            x_in = {x_ff[62:0], 1'b0};
            // remainder stays below the divisor, so 40 bits hold it
            if (rsh >= {1'b0, den_ff}) begin
               rem_in = 40'(rsh - {1'b0, den_ff});
               r_in = {r_ff[62:0], 1'b1};
            end else begin
               rem_in = rsh[39:0];
               r_in = {r_ff[62:0], 1'b0};
            end
         end
         if (step_ff == '0) busy_in = 1'b0;
         else step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= busy_ff && !busy_in && !start;
      end
      x_ff <= x_in; r_ff <= r_in; rem_ff <= rem_in; step_ff <= step_in;
      if (start) begin
         sq_ff  <= is_sqrt;
         den_ff <= den;
      end
   end
endmodule

### sv/wpa_back.sv
// Executes queued ops against the bin store: fills are a registered
// read-modify-write, reads run a sequence on the shared divide/sqrt unit.
module wpa_back #(
   parameter int NUM_BINS = wpa_pkg::NUM_BINS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   output logic                 op_ready,
   input  wpa_pkg::op_type      op,
   output logic                 res_valid,
   input  logic                 res_ready,
   output wpa_pkg::result_type  res
);
   localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_FILL  = 12'b000000000010,
      S_RLOAD = 12'b000000000100,
      S_MEAN  = 12'b000000001000,
      S_MSQ   = 12'b000000010000,
      S_VAR   = 12'b000000100000,
      S_RMS   = 12'b000001000000,
      S_R2    = 12'b000010000000,
      S_MERR  = 12'b000100000000,
      S_MSQR  = 12'b001000000000,
      S_RERR  = 12'b010000000000,
      S_OUT   = 12'b100000000000
   } state_type;

   logic [39:0] w_mem  [NUM_BINS];
   logic [55:0] s1_mem [NUM_BINS];
   logic [63:0] s2_mem [NUM_BINS];
   logic [NUM_BINS-1:0] vld_ff;

   state_type   st_ff, st_in;
   wpa_pkg::op_type op_ff;
   logic [39:0] w_rd;
   logic [55:0] s1_rd;
   logic [63:0] s2_rd;
   logic        hit_ff;
   logic [39:0] w_ff;
   logic [63:0] s2_ff, tmp_ff;
   logic        neg_ff;
   logic [16:0] q_ff;
   logic [15:0] rms_ff;
   logic [31:0] cnt_ff;
   logic        res_valid_ff;
   wpa_pkg::result_type res_ff;
   logic [AW-1:0] addr, oaddr;

   logic        du_start, du_sqrt, du_done;
   logic [63:0] du_num, du_res;
   logic [39:0] du_den;

   logic [39:0] w_cur;
   logic [55:0] s1_cur;
   logic [63:0] s2_cur;
   logic [40:0] w_sum;
   logic signed [32:0] wv;
   logic signed [56:0] s1_sum;
   logic [15:0] vmag;
   logic [31:0] vsq_ff, w32;
   logic [47:0] sq;
   logic [64:0] s2_sum;
   logic [55:0] mag;
   logic [33:0] m2;
   logic [31:0] r2;

   assign addr  = AW'(op.bin);
   assign oaddr = AW'(op_ff.bin);
   assign op_ready  = (st_ff == S_IDLE) && !res_valid_ff;
   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   wpa_divsqrt u_divsqrt (
      .clock(clock), .reset(reset), .start(du_start), .is_sqrt(du_sqrt),
      .num(du_num), .den(du_den), .done(du_done), .result(du_res)
   );

   always_comb begin
      w_cur  = hit_ff ? w_rd  : '0;
      s1_cur = hit_ff ? s1_rd : '0;
      s2_cur = hit_ff ? s2_rd : '0;
      w_sum  = {1'b0, w_cur} + {25'd0, op_ff.weight};
      wv     = $signed({1'b0, op_ff.weight}) * op_ff.value;
      s1_sum = $signed({s1_cur[55], s1_cur}) + 57'(wv);
      vmag   = op.value[15] ? 16'd0 - op.value : op.value;
      w32    = {16'd0, op_ff.weight};
      sq     = {16'd0, vsq_ff} * {16'd0, w32};
      s2_sum = {1'b0, s2_cur} + {17'd0, sq};
      mag    = s1_cur[55] ? 56'd0 - s1_cur : s1_cur;
      m2     = {17'd0, q_ff} * {17'd0, q_ff};
      r2     = {16'd0, rms_ff} * {16'd0, rms_ff};
   end

   always_comb begin
      st_in = st_ff;
      du_start = 1'b0; du_sqrt = 1'b0; du_num = '0; du_den = w_ff;
      unique case (st_ff)
         S_IDLE:  if (op_valid && op_ready)
                     st_in = (op.cmd == wpa_pkg::CMD_FILL) ? S_FILL : S_RLOAD;
         S_FILL:  st_in = S_IDLE;
         S_RLOAD: begin
            if (w_cur == '0) st_in = S_OUT;
            else begin
               du_start = 1'b1; du_num = {8'd0, mag}; du_den = w_cur;
               st_in = S_MEAN;
            end
         end
         S_MEAN: if (du_done) begin
            du_start = 1'b1; du_num = s2_ff; st_in = S_MSQ;
         end
         S_MSQ: if (du_done) st_in = S_VAR;
         S_VAR: begin
            du_start = 1'b1; du_sqrt = 1'b1;
            du_num = (tmp_ff > {30'd0, m2}) ? tmp_ff - {30'd0, m2} : '0;
            st_in = S_RMS;
         end
         S_RMS: if (du_done) st_in = (cnt_ff == '0) ? S_OUT : S_R2;
         S_R2: begin
            du_start = 1'b1; du_num = {32'd0, r2}; du_den = {8'd0, cnt_ff};
            st_in = S_MERR;
         end
         S_MERR: if (du_done) begin
            du_start = 1'b1; du_sqrt = 1'b1; du_num = du_res; st_in = S_MSQR;
         end
         S_MSQR: if (du_done) begin
            du_start = 1'b1; du_num = {tmp_ff[62:0], 1'b0};
            du_den = {8'd0, cnt_ff}; st_in = S_RERR;
         end
         S_RERR: if (du_done) begin
            du_start = 1'b1; du_sqrt = 1'b1; du_num = du_res; st_in = S_OUT;
         end
         S_OUT: if (!du_sqrt && (cnt_ff == '0 || w_ff == '0 || du_done))
                   st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         vld_ff <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (res_valid_ff && res_ready) res_valid_ff <= 1'b0;
         if (st_ff == S_FILL) vld_ff[oaddr] <= 1'b1;
         if (st_ff == S_OUT && st_in == S_IDLE) res_valid_ff <= 1'b1;
      end

      if (st_ff == S_IDLE && op_valid && op_ready) begin
         op_ff  <= op;
         hit_ff <= ({26'd0, op.bin} < 32'(NUM_BINS)) && vld_ff[addr];
         vsq_ff <= {16'd0, vmag} * {16'd0, vmag};
      end
      w_rd  <= w_mem[addr];
      s1_rd <= s1_mem[addr];
      s2_rd <= s2_mem[addr];

      if (st_ff == S_FILL) begin
         w_mem[oaddr]  <= w_sum[40] ? {40{1'b1}} : w_sum[39:0];
         s1_mem[oaddr] <= (s1_sum[56] != s1_sum[55]) ?
                          (s1_sum[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}})
                          : s1_sum[55:0];
         s2_mem[oaddr] <= s2_sum[64] ? {64{1'b1}} : s2_sum[63:0];
      end

      unique case (st_ff)
         S_RLOAD: begin
            w_ff   <= w_cur;
            s2_ff  <= s2_cur;
            neg_ff <= s1_cur[55];
            cnt_ff <= w_cur[39:8];
            res_ff <= '{read_bin: op_ff.bin, bin_mean: '0, bin_rms: '0,
                        event_count: '0, mean_error: '0, rms_error: '0,
                        bin_empty: (w_cur == '0)};
         end
         S_MEAN: if (du_done) begin
            // negative means reach one step further
            q_ff <= (du_res > (neg_ff ? 64'd32768 : 64'd32767)) ?
                    (neg_ff ? 17'd32768 : 17'd32767) : du_res[16:0];
         end
         S_MSQ: if (du_done) begin
            tmp_ff <= du_res;
            res_ff.bin_mean <= neg_ff ? 16'd0 - q_ff[15:0] : q_ff[15:0];
            res_ff.event_count <= cnt_ff;
         end
         S_RMS: if (du_done) begin
            rms_ff <= du_res[63:16] != '0 ? 16'hFFFF : du_res[15:0];
            res_ff.bin_rms <= du_res[63:16] != '0 ? 16'hFFFF : du_res[15:0];
         end
         S_R2: tmp_ff <= {32'd0, r2};
         S_MSQR: if (du_done)
            res_ff.mean_error <= du_res[63:16] != '0 ? 16'hFFFF : du_res[15:0];
         S_OUT: if (du_done && cnt_ff != '0 && w_ff != '0)
            res_ff.rms_error <= du_res[63:16] != '0 ? 16'hFFFF : du_res[15:0];
         default: ;
      endcase
   end
endmodule

### sv/wpa_checker.sv
`include "weighted_profile_accumulator_defines.svh"
module wpa_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);
   `WPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")
   `WPA_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_tvalid && rsp_tdata[102], rsp_tdata[101:6] == '0, "empty bin with nonzero stats")
   `WPA_ASSERT_IMPL(a_cnt_err, clock, reset, rsp_tvalid && rsp_tdata[69:38] == '0, rsp_tdata[101:70] == '0, "errors nonzero with zero count")
   `WPA_ASSERT_IMPL(a_pad, clock, reset, rsp_tvalid, !rsp_tdata[103], "pad bit set")
   `WPA_ASSERT_IMPL(a_req_known, clock, reset, req_tvalid, !$isunknown(req_tready), "req_tready unknown")
endmodule

bind weighted_profile_accumulator wpa_checker u_wpa_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
